// ----- hdl/mmbox_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbox_pkg
// Shared types and constants of the mipmap 2x2 box downsampler.
// ----------------------------------------------------------------------------
package mmbox_pkg;

  // Pixel format codes (the unused code behaves as rgb)
  typedef enum logic [1:0] {
    FMT_LUMA = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2
  } fmt_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;

  // Channel masks for texel packing
  localparam logic [7:0] MASK_5BIT = 8'hf8;
  localparam logic [7:0] MASK_6BIT = 8'hfc;
  localparam logic [7:0] MASK_4BIT = 8'hf0;

  // Averages are (sum of four) >> AVG_SHIFT
  localparam int AVG_SHIFT = 2;

  // Four 9-bit pair sums, channel 0 in the low bits
  localparam int LANE_W = 9;
  localparam int SUMS_W = 4 * LANE_W;

  // One result word
  typedef struct packed {
    logic [15:0] texel;
    logic [7:0]  avg3;
    logic [7:0]  avg2;
    logic [7:0]  avg1;
    logic [7:0]  avg0;
  } result_t;

  // Output queue entry
  typedef struct packed {
    logic    last;
    result_t res;
  } out_word_t;

endpackage

// ----- hdl/mipmap_box_downsample_pack_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_pack_core
// 2x2 box-filter mipmap downsampler with intensity8 / rgb565 / argb4444 pack.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: byte0, byte1, byte2, byte3
//  out_    | out | out_tvalid/tready  | tdata: avg0..avg3, texel; tlast: last
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  One source pixel per clock while in_tready is high. A result word is built
//  from the pixel that completes its 2x2 block in registered steps: the line
//  RAM read, then the average and pack into the three-word output queue.
//  Reset is synchronous; the line RAM is not cleared (even rows fill it).
//  in_tready drops only when the output queue and the RAM read stage hold
//  three words together; cfg_ready is always high.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_pack_core
  import mmbox_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // source pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // byte0, byte1, byte2, byte3
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // avg0, avg1, avg2, avg3, texel[15:0]
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int QDEPTH     = 3;

  // configuration
  logic [8:0] src_width_r, src_height_r;
  logic [1:0] pixel_format_r;
  logic       cfg_fire, cfg_hit;

  // position and held pixel
  logic [8:0]  col_r, col_nxt, row_r, row_nxt;
  logic [31:0] held_r, held_nxt;
  logic [8:0]  eff_w, eff_h, pair_cols, pair_rows;
  logic        in_fire, in_pair, is_write, is_read, is_last;
  logic [SUMS_W-1:0]  cur_sums;
  logic [LINE_AW-1:0] line_idx;

  // read stage
  logic              s1_valid_r;
  logic [SUMS_W-1:0] s1_sums_r;
  logic [1:0]        s1_fmt_r;
  logic              s1_last_r;
  logic [SUMS_W-1:0] up_sums;
  result_t           s1_res;

  // output queue
  out_word_t q_r [QDEPTH];
  logic [1:0] q_wp_r, q_rp_r, q_cnt_r;
  logic       q_pop;
  logic [2:0] in_flight;

  // config port
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index <= REG_PIXEL_FORMAT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= 9'd256;
      src_height_r   <= 9'd256;
      pixel_format_r <= FMT_RGBA;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_SRC_WIDTH:    src_width_r    <= cfg_data;
        REG_SRC_HEIGHT:   src_height_r   <= cfg_data;
        REG_PIXEL_FORMAT: pixel_format_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions: at least one, width capped at the line size
  always_comb begin
    if (src_width_r == 9'd0) begin
      eff_w = 9'd1;
    end else if (32'(src_width_r) > MAX_WIDTH) begin
      eff_w = 9'(MAX_WIDTH);
    end else begin
      eff_w = src_width_r;
    end
    eff_h     = (src_height_r == 9'd0) ? 9'd1 : src_height_r;
    pair_cols = {eff_w[8:1], 1'b0};
    pair_rows = {eff_h[8:1], 1'b0};
  end

  // decode of the current pixel
  assign in_fire  = in_tvalid && in_tready;
  assign in_pair  = col_r[0] && (col_r < pair_cols) && (row_r < pair_rows);
  assign is_write = in_fire && in_pair && !row_r[0];
  assign is_read  = in_fire && in_pair && row_r[0];
  assign is_last  = (col_r == pair_cols - 9'd1) && (row_r == pair_rows - 9'd1);
  assign line_idx = LINE_AW'(col_r[8:1]);

  // horizontal pair sums of held and current pixel
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cur_sums[k*LANE_W +: LANE_W] = {1'b0, held_r[k*8 +: 8]} + {1'b0, in_tdata[k*8 +: 8]};
    end
  end

  // position counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      held_nxt = '0;
    end else if (in_fire) begin
      if (!col_r[0]) begin
        held_nxt = in_tdata;
      end
      if ({1'b0, col_r} + 10'd1 >= {1'b0, eff_w}) begin
        col_nxt = '0;
        row_nxt = ({1'b0, row_r} + 10'd1 >= {1'b0, eff_h}) ? 9'd0 : row_r + 9'd1;
      end else begin
        col_nxt = col_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

  // line of parked pair sums
  mmbox_ram #(
    .WIDTH (SUMS_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (is_write),
    .waddr (line_idx),
    .wdata (cur_sums),
    .re    (is_read),
    .raddr (line_idx),
    .rdata (up_sums)
  );

  // read stage: registered together with the line RAM read of the parked sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      s1_sums_r <= cur_sums;
      s1_fmt_r  <= pixel_format_r;
      s1_last_r <= is_last;
    end
  end

  mmbox_pack u_pack (
    .up_sums  (up_sums),
    .cur_sums (s1_sums_r),
    .fmt      (s1_fmt_r),
    .res      (s1_res)
  );

  // output queue; read stage never stalls
  assign q_pop     = out_tvalid && out_tready;
  assign in_flight = {1'b0, q_cnt_r} + {2'b00, s1_valid_r};
  assign in_tready = in_flight < 3'(QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s1_valid_r) begin
        q_wp_r <= (q_wp_r == 2'(QDEPTH - 1)) ? 2'd0 : q_wp_r + 2'd1;
      end
      if (q_pop) begin
        q_rp_r <= (q_rp_r == 2'(QDEPTH - 1)) ? 2'd0 : q_rp_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + {1'b0, s1_valid_r} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      q_r[q_wp_r] <= '{last: s1_last_r, res: s1_res};
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_r[q_rp_r].res;
  assign out_tlast  = q_r[q_rp_r].last;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= 3'(QDEPTH))
    else $error("output queue and read stage exceed capacity");

  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    !(is_write && is_read))
    else $error("line RAM written and read by the same pixel");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == 9'd0) && (row_r == 9'd0) && (held_r == 32'd0))
    else $error("register write did not restart the level");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_read |=> s1_valid_r)
    else $error("line read lost its result");

endmodule

// ----- hdl/mmbox_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbox_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmbox_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mmbox_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbox_pack
// Adds the parked and current pair sums, averages and packs the texel.
// ----------------------------------------------------------------------------
module mmbox_pack
  import mmbox_pkg::*;
(
  input  logic [SUMS_W-1:0] up_sums,
  input  logic [SUMS_W-1:0] cur_sums,
  input  logic [1:0]        fmt,
  output result_t           res
);

  logic [7:0] a [4];

  // per-channel truncated average of four pixels
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = 8'(({1'b0, up_sums[k*LANE_W +: LANE_W]} +
                 {1'b0, cur_sums[k*LANE_W +: LANE_W]}) >> AVG_SHIFT);
    end
  end

  // format select and packing
  always_comb begin
    res.avg0 = a[0];
    res.avg1 = a[1];
    res.avg2 = a[2];
    res.avg3 = a[3];
    case (fmt)
      FMT_LUMA: begin
        res.avg1  = 8'h00;
        res.avg2  = 8'h00;
        res.avg3  = 8'h00;
        res.texel = {8'h00, a[0]};
      end
      FMT_RGBA: begin
        res.texel = {a[3] & MASK_4BIT, 8'h00} |
                    {4'h0, a[2] & MASK_4BIT, 4'h0} |
                    {8'h00, a[1] & MASK_4BIT} |
                    {12'h000, a[0][7:4]};
      end
      default: begin
        // rgb565, also for the unused code
        res.avg3  = 8'h00;
        res.texel = {a[2] & MASK_5BIT, 8'h00} |
                    {5'h00, a[1] & MASK_6BIT, 3'h0} |
                    {11'h000, a[0][7:3]};
      end
    endcase
  end

endmodule

// ----- verif/mipmap_box_downsample_pack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_pack_checker
// Passive checker for the mipmap 2x2 box downsampler. It watches the config,
// pixel and result channels and keeps its own copy of the registers, the pair
// sum line and the column/row position. Each accepted pixel is run through
// that model, and any result word it yields is queued. Each accepted result
// word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_pack_checker
  import mmbox_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // byte0, byte1, byte2, byte3
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // avg0, avg1, avg2, avg3, texel[15:0]
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          words_checked
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  // shadow registers
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [1:0] fmt_reg;

  // shadow datapath state
  logic [SUMS_W-1:0] upper_pair_sums [LINE_DEPTH];
  logic [31:0]       even_col_px;
  int unsigned       col;
  int unsigned       row;

  // predicted next-level texels, oldest first
  out_word_t mip_texel_q [$];

  function automatic logic [SUMS_W-1:0] channel_pair_sums(input logic [31:0] a,
                                                          input logic [31:0] b);
    logic [SUMS_W-1:0] s;
    int k;
    s = '0;
    for (k = 0; k < 4; k++)
      s[k*LANE_W +: LANE_W] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
    return s;
  endfunction

  task automatic restart_level();
    even_col_px = '0;
    col = 0;
    row = 0;
  endtask

  // register write; an index outside the register file changes nothing
  task automatic write_shadow(input logic [1:0] idx, input logic [8:0] val);
    case (idx)
      REG_SRC_WIDTH: begin
        width_reg = val;
        restart_level();
      end
      REG_SRC_HEIGHT: begin
        height_reg = val;
        restart_level();
      end
      REG_PIXEL_FORMAT: begin
        fmt_reg = val[1:0];
        restart_level();
      end
      default: ;
    endcase
  endtask

  // advance the model by one source pixel, queueing a texel when a 2x2 block closes
  task automatic downsample_pixel(input logic [31:0] px);
    int unsigned w, h, pair_cols, pair_rows, idx;
    logic [SUMS_W-1:0] s, up;
    logic [9:0] tot;
    logic [7:0] a [4];
    out_word_t word;
    int k;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 1) ? 1 : height_reg;
    pair_cols = (w / 2) * 2;
    pair_rows = (h / 2) * 2;

    if (col % 2 == 0) begin
      even_col_px = px;
    end else if (col < pair_cols && row < pair_rows) begin
      idx = (col / 2) % LINE_DEPTH;
      s = channel_pair_sums(even_col_px, px);
      if (row % 2 == 0) begin
        upper_pair_sums[idx] = s;
      end else begin
        up = upper_pair_sums[idx];
        for (k = 0; k < 4; k++) begin
          tot = {1'b0, up[k*LANE_W +: LANE_W]} + {1'b0, s[k*LANE_W +: LANE_W]};
          a[k] = 8'(tot >> AVG_SHIFT);
        end
        word.res.avg0 = a[0];
        word.res.avg1 = a[1];
        word.res.avg2 = a[2];
        word.res.avg3 = a[3];
        case (fmt_reg)
          FMT_LUMA: begin
            word.res.avg1  = '0;
            word.res.avg2  = '0;
            word.res.avg3  = '0;
            word.res.texel = {8'h00, a[0]};
          end
          FMT_RGBA: begin
            word.res.texel = {a[3][7:4], a[2][7:4], a[1][7:4], a[0][7:4]};
          end
          // rgb and the spare code both pack rgb565
          default: begin
            word.res.avg3  = '0;
            word.res.texel = {a[2][7:3], a[1][7:2], a[0][7:3]};
          end
        endcase
        word.last = (col == pair_cols - 1) && (row == pair_rows - 1);
        mip_texel_q.push_back(word);
      end
    end

    // position update, wrapping at end of row and end of level
    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) row = 0;
      else row++;
    end else begin
      col++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // channel monitor: result first, so a word can never match a prediction of its own edge
  always @(posedge clk) begin : watch
    result_t   got;
    out_word_t want;
    if (!rst_n) begin
      width_reg  = 9'd256;
      height_reg = 9'd256;
      fmt_reg    = FMT_RGBA;
      restart_level();
      mip_texel_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (mip_texel_q.size() == 0) begin
          $error("result word with nothing predicted: tdata %h tlast %b",
                 out_tdata, out_tlast);
          errors++;
        end else begin
          want = mip_texel_q.pop_front();
          check_field("avg0", want.res.avg0, got.avg0);
          check_field("avg1", want.res.avg1, got.avg1);
          check_field("avg2", want.res.avg2, got.avg2);
          check_field("avg3", want.res.avg3, got.avg3);
          check_field("texel", want.res.texel, got.texel);
          check_field("last", want.last, out_tlast);
          words_checked++;
        end
      end
      if (cfg_valid && cfg_ready) write_shadow(cfg_index, cfg_data);
      if (in_tvalid && in_tready) downsample_pixel(in_tdata);
    end
    pending <= mip_texel_q.size();
  end

endmodule

// ----- verif/mipmap_box_downsample_pack_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_pack_core_tb
// Stimulus and verdict for the mipmap 2x2 box downsampler. A directed set of
// tiny levels covers saturated and empty channels, every pixel format and
// degenerate sizes. Random levels then follow, of mixed size and partial or
// repeated, with random idle gaps on the pixel side and stalls on the result
// side. The checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_pack_core_tb
  import mmbox_pkg::*;
();

  localparam int         MAX_W         = 256;
  localparam int         MAX_GAP       = 12;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         DRAIN_GUARD   = 5000;
  localparam int         RANDOM_PIXELS = 2000;
  localparam logic [1:0] FMT_SPARE     = 2'd3;  // unused format code, packs as rgb
  localparam logic [1:0] REG_NONE      = 2'd3;  // index past the register file
  localparam logic [3:0] WR_ALL        = 4'b0111;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int errors;
  int pending;
  int words_checked;

  // stimulus bookkeeping
  int         pixels_sent;
  int         settings_run;
  bit         calm_in;
  bit         calm_out;
  logic [8:0] cur_w;
  logic [8:0] cur_h;

  mipmap_box_downsample_pack_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mipmap_box_downsample_pack_checker #(
    .MAX_WIDTH(MAX_W)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .words_checked(words_checked)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #5_000_000;
    $error("run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // bytes lean toward 0x00 and 0xff so the sums hit both ends
  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    int k;
    int pick;
    for (k = 0; k < 4; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) px[8*k +: 8] = 8'h00;
      else if (pick <= 2) px[8*k +: 8] = 8'hff;
      else px[8*k +: 8] = 8'($urandom);
    end
    return px;
  endfunction

  // pixels in one level at the current size (sizing hint only)
  function automatic int level_pixels();
    int w;
    int h;
    w = (cur_w < 1) ? 1 : (cur_w > MAX_W) ? MAX_W : cur_w;
    h = (cur_h < 1) ? 1 : cur_h;
    return w * h;
  endfunction

  // result side: random stall before each word
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap(calm_out);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // one config word; cfg_valid is left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // sel bit i writes register i, bit 3 pokes the unused index
  task automatic configure(input logic [8:0] w, input logic [8:0] h,
                           input logic [1:0] fmt, input logic [3:0] sel);
    if (sel[3]) write_reg(REG_NONE, 9'($urandom));
    if (sel[0]) begin
      write_reg(REG_SRC_WIDTH, w);
      cur_w = w;
    end
    if (sel[1]) begin
      write_reg(REG_SRC_HEIGHT, h);
      cur_h = h;
    end
    if (sel[2]) write_reg(REG_PIXEL_FORMAT, {7'd0, fmt});
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // one pixel word; in_tvalid stays high unless the next word draws a gap
  task automatic push_pixel(input logic [31:0] px);
    int gap;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // stop feeding, wait for every predicted word, then let the pipeline empty
  task automatic settle();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_GUARD);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d result words never arrived", pending);
  endtask

  task automatic block_2x2(input logic [1:0] fmt, input logic [3:0] sel,
                           input logic [31:0] p0, input logic [31:0] p1,
                           input logic [31:0] p2, input logic [31:0] p3);
    configure(9'd2, 9'd2, fmt, sel);
    push_pixel(p0);
    push_pixel(p1);
    push_pixel(p2);
    push_pixel(p3);
    settle();
  endtask

  // stimulus
  initial begin : stimulus
    int sel;
    int mode;
    int npix;
    int lvl;
    int random_start;
    logic [8:0] w;
    logic [8:0] h;
    logic [3:0] wr;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SRC_WIDTH;
    cfg_data  <= '0;
    calm_in   = 1'b0;
    calm_out  = 1'b0;
    cur_w     = 9'd256;
    cur_h     = 9'd256;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturated channels, truncation, each format, degenerate sizes
    block_2x2(FMT_RGBA, WR_ALL, '1, '1, '1, '1);
    block_2x2(FMT_RGBA, WR_ALL, 32'h0000_0000, 32'hffff_ffff,
              32'h0302_0100, 32'hfcfd_feff);
    block_2x2(FMT_LUMA, WR_ALL, 32'h5a5a_a5ff, 32'hffff_ffff,
              32'h1234_56ff, 32'h00ff_00fe);
    block_2x2(FMT_RGB, WR_ALL, '1, '1, '1, '1);
    block_2x2(FMT_SPARE, 4'b1111, rand_pixel(), rand_pixel(), rand_pixel(),
              rand_pixel());
    // zero width counts as one column: no texel
    configure(9'd0, 9'd2, FMT_RGB, WR_ALL);
    repeat (3) push_pixel(rand_pixel());
    settle();
    // zero height counts as one row: no texel
    configure(9'd2, 9'd0, FMT_RGBA, WR_ALL);
    repeat (2) push_pixel(rand_pixel());
    settle();

    // random levels
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        w = 9'd256;
        h = 9'($urandom_range(2, 3));
      end else if (sel == 1) begin
        w = $urandom_range(0, 1) ? 9'd511 : 9'($urandom_range(257, 511));
        h = 9'd2;
      end else if (sel == 2) begin
        w = 9'd2;
        h = 9'($urandom_range(0, 511));
      end else if (sel == 3) begin
        w = 9'($urandom_range(0, 1));
        h = 9'($urandom_range(0, 8));
      end else if (sel == 4) begin
        w = 9'($urandom_range(2, 8));
        h = 9'($urandom_range(0, 1));
      end else begin
        w = 9'($urandom_range(2, 24));
        h = 9'($urandom_range(2, 12));
      end
      wr = ($urandom_range(0, 9) == 0) ? 4'($urandom) : WR_ALL;
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      configure(w, h, 2'($urandom), wr);

      // whole level, a cut-off level, or a wrap into the next level
      lvl  = level_pixels();
      mode = $urandom_range(0, 9);
      if (mode < 6) npix = lvl;
      else if (mode < 8) npix = $urandom_range(1, lvl);
      else npix = 2 * lvl + $urandom_range(0, 2 * lvl);
      if (npix > 1200) npix = 1200;
      // the last level is cut to the pixel budget
      if (npix > RANDOM_PIXELS - (pixels_sent - random_start))
        npix = RANDOM_PIXELS - (pixels_sent - random_start);
      repeat (npix) push_pixel(rand_pixel());
      settle();
    end

    $display("Sent %0d pixels under %0d register settings; %0d result words compared.",
             pixels_sent, settings_run, words_checked);
    $display("Covered all formats and the spare code, widths and heights 0..511, %s",
             "partial and wrapped levels, gaps and stalls on both sides.");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
